FILE: design/dpr_pkg.sv
// shared types and constants for the dib pixel to rgb888 converter
`timescale 1ns / 1ps

package dpr_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned FmtW    = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned ShiftW  = 6;

  localparam logic [DataW-1:0] RedMaskRst   = 32'h0000_7C00;
  localparam logic [DataW-1:0] GreenMaskRst = 32'h0000_03E0;
  localparam logic [DataW-1:0] BlueMaskRst  = 32'h0000_001F;

  typedef enum logic [FmtW-1:0] {
    FMT_RGB555 = 3'd0,
    FMT_BGR24  = 3'd1,
    FMT_XRGB32 = 3'd2,
    FMT_BF16   = 3'd3,
    FMT_BF32   = 3'd4
  } fmt_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FORMAT = 2'd0,
    REG_RED    = 2'd1,
    REG_GREEN  = 2'd2,
    REG_BLUE   = 2'd3
  } cfg_idx_e;

  // mask plus net right shift (negative means shift left)
  typedef struct packed {
    logic [DataW-1:0]         mask;
    logic signed [ShiftW-1:0] shift;
  } chan_cfg_t;

endpackage

FILE: design/dpr_cfg_regs.sv
// configuration registers with per-channel shift decode done at write time
`timescale 1ns / 1ps

module dpr_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dpr_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [dpr_pkg::DataW-1:0]         cfg_data_i,
  output logic [dpr_pkg::FmtW-1:0]          fmt_o,
  output dpr_pkg::chan_cfg_t                red_cfg_o,
  output dpr_pkg::chan_cfg_t                green_cfg_o,
  output dpr_pkg::chan_cfg_t                blue_cfg_o
);

  // position of lowest set bit of a 33-bit value
  function automatic logic [5:0] low_one_pos(input logic [dpr_pkg::DataW:0] v);
    logic [5:0] pos;
    pos = '0;
    for (int i = dpr_pkg::DataW; i >= 0; i--) begin
      if (v[i]) begin
        pos = 6'(i);
      end
    end
    return pos;
  endfunction

  // net right shift = end of lowest run of ones minus eight
  function automatic dpr_pkg::chan_cfg_t decode(input logic [dpr_pkg::DataW-1:0] m);
    logic [dpr_pkg::DataW-1:0] low_bit;
    logic [dpr_pkg::DataW:0]   run_end;
    dpr_pkg::chan_cfg_t        c;
    low_bit = m & (~m + 1'b1);
    // adding the lowest set bit clears the lowest run; its carry marks the run end
    run_end = {1'b0, m} + {1'b0, low_bit};
    c.mask  = m;
    c.shift = $signed(low_one_pos(run_end)) - 6'sd8;
    return c;
  endfunction

  localparam dpr_pkg::chan_cfg_t RedRst   = decode(dpr_pkg::RedMaskRst);
  localparam dpr_pkg::chan_cfg_t GreenRst = decode(dpr_pkg::GreenMaskRst);
  localparam dpr_pkg::chan_cfg_t BlueRst  = decode(dpr_pkg::BlueMaskRst);

  logic [dpr_pkg::FmtW-1:0] fmt_q;
  dpr_pkg::chan_cfg_t       red_q, green_q, blue_q;
  dpr_pkg::chan_cfg_t       dec_d;

  assign dec_d = decode(cfg_data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q   <= dpr_pkg::FMT_RGB555;
      red_q   <= RedRst;
      green_q <= GreenRst;
      blue_q  <= BlueRst;
    end else if (cfg_we_i) begin
      case (dpr_pkg::cfg_idx_e'(cfg_idx_i))
        dpr_pkg::REG_FORMAT: fmt_q   <= cfg_data_i[dpr_pkg::FmtW-1:0];
        dpr_pkg::REG_RED:    red_q   <= dec_d;
        dpr_pkg::REG_GREEN:  green_q <= dec_d;
        dpr_pkg::REG_BLUE:   blue_q  <= dec_d;
        default: ;
      endcase
    end
  end

  assign fmt_o       = fmt_q;
  assign red_cfg_o   = red_q;
  assign green_cfg_o = green_q;
  assign blue_cfg_o  = blue_q;

endmodule

FILE: design/dpr_channel.sv
// one bitfield channel: mask, then a single signed barrel shift, keep 8 bits
`timescale 1ns / 1ps

module dpr_channel (
  input  logic [dpr_pkg::DataW-1:0] pixel_i,
  input  dpr_pkg::chan_cfg_t        cfg_i,
  output logic [dpr_pkg::ChanW-1:0] field_o
);

  logic [dpr_pkg::DataW-1:0]  masked;
  logic [dpr_pkg::DataW-1:0]  shifted;
  logic [dpr_pkg::ShiftW-1:0] neg_amt;

  assign masked  = pixel_i & cfg_i.mask;
  assign neg_amt = dpr_pkg::ShiftW'(-cfg_i.shift);

  // bits below the mask are zero, so a left shift equals the model's right-then-left
  always_comb begin
    if (cfg_i.shift < 0) begin
      shifted = masked << neg_amt[2:0];
    end else begin
      shifted = masked >> cfg_i.shift[dpr_pkg::ShiftW-2:0];
    end
  end

  assign field_o = shifted[dpr_pkg::ChanW-1:0];

endmodule

FILE: design/dib_pixel_to_rgb888.sv
// top level: pixel input register, format select and channel extract, result register
`timescale 1ns / 1ps

// Converts one little-endian source pixel word per clock into 8-bit red, green and
// blue. An item is taken at each rising edge where start is high (busy stays low,
// so a new pixel may follow every cycle). It is held in the input register, converted
// in the next cycle and its result sits on red_o/green_o/blue_o with done_o high for
// exactly one cycle, loaded by the result register; the receiver cannot stall.
// Throughput is one item per cycle, set by the input and result register pair.
// Bitfield shifts are decoded when a mask is written, so configuration must only be
// written while no item is in flight.
module dib_pixel_to_rgb888 (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [dpr_pkg::DataW-1:0]   pixel_word_i,
  input  logic                        cfg_we_i,
  input  logic [dpr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [dpr_pkg::DataW-1:0]   cfg_data_i,
  output logic                        done_o,
  output logic [dpr_pkg::ChanW-1:0]   red_o,
  output logic [dpr_pkg::ChanW-1:0]   green_o,
  output logic [dpr_pkg::ChanW-1:0]   blue_o
);

  logic [dpr_pkg::FmtW-1:0]  fmt;
  dpr_pkg::chan_cfg_t        red_cfg, green_cfg, blue_cfg;

  logic                      pix_vld_q;
  logic [dpr_pkg::DataW-1:0] pix_q;
  logic [dpr_pkg::DataW-1:0] bf_pix;
  logic [dpr_pkg::ChanW-1:0] bf_r, bf_g, bf_b;
  logic [dpr_pkg::ChanW-1:0] red_d, green_d, blue_d;
  logic [dpr_pkg::ChanW-1:0] red_q, green_q, blue_q;
  logic                      done_q;
  logic                      accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  dpr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .fmt_o       (fmt),
    .red_cfg_o   (red_cfg),
    .green_cfg_o (green_cfg),
    .blue_cfg_o  (blue_cfg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_vld_q <= 1'b0;
    end else begin
      pix_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q <= pixel_word_i;
    end
  end

  // 16-bit bitfields see only the low half of the word
  assign bf_pix = (dpr_pkg::fmt_e'(fmt) == dpr_pkg::FMT_BF16) ?
                  {16'h0000, pix_q[15:0]} : pix_q;

  dpr_channel u_red   (.pixel_i(bf_pix), .cfg_i(red_cfg),   .field_o(bf_r));
  dpr_channel u_green (.pixel_i(bf_pix), .cfg_i(green_cfg), .field_o(bf_g));
  dpr_channel u_blue  (.pixel_i(bf_pix), .cfg_i(blue_cfg),  .field_o(bf_b));

  always_comb begin
    red_d   = '0;
    green_d = '0;
    blue_d  = '0;
    case (dpr_pkg::fmt_e'(fmt))
      dpr_pkg::FMT_RGB555: begin
        red_d   = {pix_q[14:10], 3'b000};
        green_d = {pix_q[9:5], 3'b000};
        blue_d  = {pix_q[4:0], 3'b000};
      end
      dpr_pkg::FMT_BGR24, dpr_pkg::FMT_XRGB32: begin
        red_d   = pix_q[23:16];
        green_d = pix_q[15:8];
        blue_d  = pix_q[7:0];
      end
      dpr_pkg::FMT_BF16, dpr_pkg::FMT_BF32: begin
        red_d   = bf_r;
        green_d = bf_g;
        blue_d  = bf_b;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= pix_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_vld_q) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign done_o  = done_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

  a_accept_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> pix_vld_q)
    else $error("accepted item did not reach the input register");

  a_item_to_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_vld_q |=> done_o)
    else $error("item in input register produced no result");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_vld_q |=> !done_o)
    else $error("result strobe without an item");

  a_zero_mask : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_vld_q && dpr_pkg::fmt_e'(fmt) == dpr_pkg::FMT_BF32 && red_cfg.mask == '0)
    |=> (red_o == '0))
    else $error("zero red mask gave a nonzero field");

endmodule
